FILE: hw/rtl/framed_video_stream_deframer_top_defines.svh
// Assertion macros for the framed video stream deframer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef FRAMED_VIDEO_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define FRAMED_VIDEO_STREAM_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only while out of reset
`define DFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define DFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFR_ASSERT(lbl, prop, msg)
`define DFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/dfr_pkg.sv
// Shared types, codes and constants of the framed video stream deframer.
// No dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

	localparam int LENGTH_BITS   = 25;
	localparam int MAX_DIMENSION = 8192;
	localparam int MIN_DIMENSION = 16;
	localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
	localparam int PROD_W        = 2 * DIM_W;

	localparam logic [31:0] STREAM_MAGIC = 32'h3248_4243;
	localparam logic [31:0] DIM_LO       = 32'(MIN_DIMENSION);
	localparam logic [31:0] DIM_HI       = 32'(MAX_DIMENSION);
	localparam logic [31:0] LEN_CAP      = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [3:0] HDR_LAST_IDX = 4'd15;
	localparam logic [3:0] HDR_TAIL_IDX = 4'd12;

	localparam logic [31:0] MAX_FRAME_RST  = 32'd3110400;
	localparam logic [24:0] MAX_PACKET_RST = 25'd16777216;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_FRAME  = 2'd0;
	localparam logic [1:0] CFG_MAX_PACKET = 2'd1;

	// event codes
	localparam logic [1:0] EV_READY = 2'd0;
	localparam logic [1:0] EV_BYTE  = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_DIMENSION = 3'd2;
	localparam logic [2:0] ERR_FRAME_CAP = 3'd3;
	localparam logic [2:0] ERR_LENGTH    = 3'd4;

	typedef enum logic [1:0] {
		PH_STREAM  = 2'd0,
		PH_PACKET  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_HALT    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [31:0] max_frame_bytes;
		logic [24:0] max_packet_bytes;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       event_res;
		logic [7:0]       payload_byte;
		logic             last_in_packet;
		logic             key_frame;
		logic [63:0]      timestamp_us;
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [31:0]      frame_rate;
		logic [2:0]       error_code;
	} res_t;

	function automatic logic dim_ok(input logic [31:0] v);
		return (v >= DIM_LO) && (v <= DIM_HI);
	endfunction

endpackage

FILE: hw/rtl/dfr_cfg_regs.sv
// Configuration registers of the deframer: frame byte cap and packet length cap.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output dfr_pkg::cfg_t cfg
);

	logic [31:0] max_frame_q;
	logic [24:0] max_packet_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q  <= dfr_pkg::MAX_FRAME_RST;
			max_packet_q <= dfr_pkg::MAX_PACKET_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dfr_pkg::CFG_MAX_FRAME: begin
					max_frame_q <= cfg_data;
				end
				dfr_pkg::CFG_MAX_PACKET: begin
					max_packet_q <= cfg_data[24:0];
				end
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	assign cfg.max_frame_bytes  = max_frame_q;
	assign cfg.max_packet_bytes = max_packet_q;

endmodule

FILE: hw/rtl/dfr_parser.sv
// Stream parser of the deframer: header assembly, checks and payload tagging.
// Depends on dfr_pkg. State advances once per step_en.
`timescale 1ns / 1ps

module dfr_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  logic [7:0]     data_byte,
	input  logic           new_connection,
	input  dfr_pkg::cfg_t  cfg,
	output logic           res_valid,
	output dfr_pkg::res_t  res
);

	localparam int DW = dfr_pkg::DIM_W;
	localparam int PW = dfr_pkg::PROD_W;

	dfr_pkg::phase_t phase_q, phase_d, phase_c;

	logic [3:0]                     cnt_q, cnt_d, cnt_c;
	logic [2:0][31:0]               hdr_words_q;
	logic [23:0]                    tail_q;
	logic [dfr_pkg::LENGTH_BITS-1:0] left_q, left_d, left_c;
	logic                           key_q, key_d, key_c;
	logic [63:0]                    time_q, time_d, time_c;
	logic [DW-1:0]                  width_q, width_d, width_c;
	logic [DW-1:0]                  height_q, height_d, height_c;
	logic [31:0]                    rate_q, rate_d, rate_c;
	logic [PW-1:0]                  prod_q;
	logic [PW+1:0]                  prod_x3;
	logic [31:0]                    frame_bytes;
	logic [31:0]                    len_cap;
	logic                           hdr_phase;
	logic                           last;

	// w*h over the stored words; settles long before the closing header byte
	always_ff @(posedge clk) begin
		prod_q <= hdr_words_q[1][DW-1:0] * hdr_words_q[2][DW-1:0];
	end

	assign prod_x3     = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
	assign frame_bytes = 32'(prod_x3[PW+1:1]);
	assign len_cap     = ({7'd0, cfg.max_packet_bytes} < dfr_pkg::LEN_CAP) ?
	                     {7'd0, cfg.max_packet_bytes} : dfr_pkg::LEN_CAP;

	always_comb begin
		phase_c  = new_connection ? dfr_pkg::PH_STREAM : phase_q;
		cnt_c    = new_connection ? 4'd0 : cnt_q;
		left_c   = new_connection ? '0 : left_q;
		key_c    = new_connection ? 1'b0 : key_q;
		time_c   = new_connection ? 64'd0 : time_q;
		width_c  = new_connection ? '0 : width_q;
		height_c = new_connection ? '0 : height_q;
		rate_c   = new_connection ? 32'd0 : rate_q;

		hdr_phase = (phase_c == dfr_pkg::PH_STREAM) || (phase_c == dfr_pkg::PH_PACKET);
		last      = (left_c <= dfr_pkg::LENGTH_BITS'(1));

		phase_d  = phase_c;
		cnt_d    = cnt_c;
		left_d   = left_c;
		key_d    = key_c;
		time_d   = time_c;
		width_d  = width_c;
		height_d = height_c;
		rate_d   = rate_c;

		res_valid          = 1'b0;
		res.event_res      = dfr_pkg::EV_BYTE;
		res.payload_byte   = 8'd0;
		res.last_in_packet = 1'b0;
		res.key_frame      = 1'b0;
		res.timestamp_us   = 64'd0;
		res.frame_width    = width_c;
		res.frame_height   = height_c;
		res.frame_rate     = rate_c;
		res.error_code     = dfr_pkg::ERR_NONE;

		unique case (phase_c)
			dfr_pkg::PH_HALT: begin
				// ignore bytes until the next connection
			end
			dfr_pkg::PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.payload_byte   = data_byte;
				res.last_in_packet = last;
				res.key_frame      = key_c;
				res.timestamp_us   = time_c;
				if (last) begin
					left_d  = '0;
					phase_d = dfr_pkg::PH_PACKET;
				end else begin
					left_d = left_c - dfr_pkg::LENGTH_BITS'(1);
				end
			end
			dfr_pkg::PH_STREAM, dfr_pkg::PH_PACKET: begin
				if (cnt_c != dfr_pkg::HDR_LAST_IDX) begin
					cnt_d = cnt_c + 4'd1;
				end else begin
					cnt_d = 4'd0;
					if (phase_c == dfr_pkg::PH_STREAM) begin
						res_valid = 1'b1;
						priority if (hdr_words_q[0] != dfr_pkg::STREAM_MAGIC) begin
							res.event_res  = dfr_pkg::EV_ERROR;
							res.error_code = dfr_pkg::ERR_MAGIC;
							phase_d        = dfr_pkg::PH_HALT;
						end else if (!dfr_pkg::dim_ok(hdr_words_q[1]) ||
						             !dfr_pkg::dim_ok(hdr_words_q[2])) begin
							res.event_res  = dfr_pkg::EV_ERROR;
							res.error_code = dfr_pkg::ERR_DIMENSION;
							phase_d        = dfr_pkg::PH_HALT;
						end else if (frame_bytes > cfg.max_frame_bytes) begin
							res.event_res  = dfr_pkg::EV_ERROR;
							res.error_code = dfr_pkg::ERR_FRAME_CAP;
							phase_d        = dfr_pkg::PH_HALT;
						end else begin
							width_d          = hdr_words_q[1][DW-1:0];
							height_d         = hdr_words_q[2][DW-1:0];
							rate_d           = {data_byte, tail_q};
							res.event_res    = dfr_pkg::EV_READY;
							res.frame_width  = hdr_words_q[1][DW-1:0];
							res.frame_height = hdr_words_q[2][DW-1:0];
							res.frame_rate   = {data_byte, tail_q};
							phase_d          = dfr_pkg::PH_PACKET;
						end
					end else begin
						if ((hdr_words_q[0] == 32'd0) || (hdr_words_q[0] > len_cap)) begin
							res_valid      = 1'b1;
							res.event_res  = dfr_pkg::EV_ERROR;
							res.error_code = dfr_pkg::ERR_LENGTH;
							phase_d        = dfr_pkg::PH_HALT;
						end else begin
							left_d  = hdr_words_q[0][dfr_pkg::LENGTH_BITS-1:0];
							key_d   = hdr_words_q[1][0];
							time_d  = {data_byte, tail_q, hdr_words_q[2]};
							phase_d = dfr_pkg::PH_PAYLOAD;
						end
					end
				end
			end
		endcase
	end

	// header byte lanes; every lane is rewritten before it is read
	always_ff @(posedge clk) begin
		if (step_en && hdr_phase) begin
			if (cnt_c < dfr_pkg::HDR_TAIL_IDX) begin
				hdr_words_q[cnt_c[3:2]][{cnt_c[1:0], 3'b000} +: 8] <= data_byte;
			end else if (cnt_c != dfr_pkg::HDR_LAST_IDX) begin
				tail_q[{cnt_c[1:0], 3'b000} +: 8] <= data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dfr_pkg::PH_STREAM;
			cnt_q    <= 4'd0;
			left_q   <= '0;
			key_q    <= 1'b0;
			time_q   <= 64'd0;
			width_q  <= '0;
			height_q <= '0;
			rate_q   <= 32'd0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			left_q   <= left_d;
			key_q    <= key_d;
			time_q   <= time_d;
			width_q  <= width_d;
			height_q <= height_d;
			rate_q   <= rate_d;
		end
	end

endmodule

FILE: hw/rtl/framed_video_stream_deframer_top.sv
// Block usage:
// Takes a connection byte stream on the byte channel (data_byte, new_connection,
// byte_valid/byte_stall) and delivers events on the event channel
// (evt_valid/evt_stall): stream ready after a good 16-byte stream header,
// one event per payload byte, or an error that halts parsing.
// Raising new_connection with a byte restarts parsing at that byte.
// A byte is registered in the input register, parsed from there, and its event is
// registered in the event register, from which the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall, set by the single
// parse step between the input register and the event register.
// Header bytes other than the last stream header byte, halted bytes and accepted packet headers give no event.
// When the receiver stalls, the event register holds; one more byte is taken
// into the input register, then byte_stall rises until the event is taken.
// Reset clears the parser to the stream header and the caps to their
// defaults (3110400 frame bytes, 16777216 packet bytes).
// Configuration writes via cfg_wr_en/cfg_index/cfg_data, only while idle.
// Depends on dfr_pkg, dfr_cfg_regs, dfr_parser and the assertion header.
`timescale 1ns / 1ps
`include "framed_video_stream_deframer_top_defines.svh"

module framed_video_stream_deframer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        new_connection,
	output logic                        evt_valid,
	input  logic                        evt_stall,
	output logic [1:0]                  event_res,
	output logic [7:0]                  payload_byte,
	output logic                        last_in_packet,
	output logic                        key_frame,
	output logic signed [63:0]          timestamp_us,
	output logic [dfr_pkg::DIM_W-1:0]   frame_width,
	output logic [dfr_pkg::DIM_W-1:0]   frame_height,
	output logic [31:0]                 frame_rate,
	output logic [2:0]                  error_code
);

	dfr_pkg::cfg_t cfg;
	dfr_pkg::res_t res;
	dfr_pkg::res_t res_s2;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       newconn_s1;
	logic       valid_s2;
	logic       advance;
	logic       step_en;
	logic       res_valid;

	assign advance    = !valid_s2 || !evt_stall;
	assign step_en    = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1    <= data_byte;
			newconn_s1 <= new_connection;
		end
	end

	dfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dfr_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (step_en),
		.data_byte      (byte_s1),
		.new_connection (newconn_s1),
		.cfg            (cfg),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign evt_valid      = valid_s2;
	assign event_res      = res_s2.event_res;
	assign payload_byte   = res_s2.payload_byte;
	assign last_in_packet = res_s2.last_in_packet;
	assign key_frame      = res_s2.key_frame;
	assign timestamp_us   = res_s2.timestamp_us;
	assign frame_width    = res_s2.frame_width;
	assign frame_height   = res_s2.frame_height;
	assign frame_rate     = res_s2.frame_rate;
	assign error_code     = res_s2.error_code;

	`DFR_ASSERT(a_stall_only_when_held, byte_stall |-> valid_s1, "byte stall without a held byte")
	`DFR_ASSERT(a_error_has_code, (evt_valid && (event_res == dfr_pkg::EV_ERROR)) |-> (error_code != dfr_pkg::ERR_NONE), "error event without a code")
	`DFR_ASSERT(a_ready_dims, (evt_valid && (event_res == dfr_pkg::EV_READY)) |-> ((frame_width >= dfr_pkg::DIM_W'(dfr_pkg::MIN_DIMENSION)) && (frame_height >= dfr_pkg::DIM_W'(dfr_pkg::MIN_DIMENSION))), "ready with dimensions out of range")
	`DFR_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !evt_valid, "event right after reset")

endmodule
